/* rtl/core/stbs_pkg.sv */
package stbs_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned POS_W  = 10;
  localparam int unsigned DATA_W = 32;

  // Command codes carried on the command port.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Search sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COMPARE,
    ST_REPORT
  } state_t;

endpackage

/* rtl/core/sorted_table_binary_search.sv */
// Channel   Ports                                                    Handshake
// input     command, position, data_value, range_low, range_high     start high, busy low
// result    found                                                    done high, one cycle
//
// A write item stores its entry on the accepting edge if its position is in the table.
// A search item makes P probes, P being at most floor(log2(range size)) + 1, so 11 for
// the full table. Each probe addresses the single-port table memory in the read state
// and compares its registered read data in the compare state. The result is shown in
// the report state, after which the next item can be taken; an empty range has P = 0.
// Reset is synchronous and returns the sequencer to idle; the table keeps its contents.
// Results cannot be stalled by the receiver.
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                command,
  input  logic [stbs_pkg::POS_W-1:0]          position,
  input  logic signed [stbs_pkg::DATA_W-1:0]  data_value,
  input  logic [stbs_pkg::POS_W-1:0]          range_low,
  input  logic [stbs_pkg::POS_W-1:0]          range_high,
  output logic                                done,
  output logic                                found
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [stbs_pkg::DATA_W-1:0] ram_wdata;
  logic [stbs_pkg::DATA_W-1:0] ram_rdata;

  // Sequencer with the shared compare unit.
  stbs_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .position  (position),
    .data_value(data_value),
    .range_low (range_low),
    .range_high(range_high),
    .busy      (busy),
    .done      (done),
    .found     (found),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  // Entry table.
  stbs_ram #(
    .WIDTH(stbs_pkg::DATA_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

endmodule

/* rtl/core/stbs_ram.sv */
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: write, or a read whose data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/stbs_seq.sv */
module stbs_seq #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                command,
  input  logic [stbs_pkg::POS_W-1:0]          position,
  input  logic signed [stbs_pkg::DATA_W-1:0]  data_value,
  input  logic [stbs_pkg::POS_W-1:0]          range_low,
  input  logic [stbs_pkg::POS_W-1:0]          range_high,
  output logic                                busy,
  output logic                                done,
  output logic                                found,
  output logic                                ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]      ram_addr,
  output logic [stbs_pkg::DATA_W-1:0]         ram_wdata,
  input  logic [stbs_pkg::DATA_W-1:0]         ram_rdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned PW = stbs_pkg::POS_W;
  // Common width wide enough for both a position and a table address.
  localparam int unsigned XW = (AW > PW) ? AW : PW;
  localparam logic [XW:0] DEPTH_V = (XW + 1)'(TABLE_DEPTH);
  localparam logic [XW:0] LAST_V  = (XW + 1)'(TABLE_DEPTH - 1);

  stbs_pkg::state_t state, state_next;

  logic [PW-1:0]                      lo, lo_next;
  logic [PW-1:0]                      hi, hi_next;
  logic [PW-1:0]                      mid;
  logic signed [stbs_pkg::DATA_W-1:0] key;
  logic                               found_next;

  logic                               accept;
  logic                               is_search;
  logic [PW-1:0]                      hi_clamped;
  logic                               range_empty;
  logic [PW:0]                        mid_sum;
  logic [PW-1:0]                      mid_calc;
  logic signed [stbs_pkg::DATA_W-1:0] probe;
  logic                               hit;
  logic                               go_up;
  logic                               go_down;
  logic                               pos_in_table;

  assign accept    = start && (state == stbs_pkg::ST_IDLE);
  assign is_search = (command == stbs_pkg::CMD_SEARCH);

  // Clamp the upper bound of the range to the last table position.
  always_comb begin
    if ((XW + 1)'(range_high) >= DEPTH_V) begin
      hi_clamped = LAST_V[PW-1:0];
    end else begin
      hi_clamped = range_high;
    end
  end

  assign range_empty  = (range_low > hi_clamped);
  assign pos_in_table = ((XW + 1)'(position) < DEPTH_V);

  // Truncated midpoint of the current range.
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_calc = mid_sum[PW:1];

  // Shared compare unit: one probed entry against the key.
  assign probe   = $signed(ram_rdata);
  assign hit     = (probe == key);
  assign go_up   = (probe < key) && (mid < hi);
  assign go_down = (probe > key) && (mid > lo);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      stbs_pkg::ST_IDLE: begin
        if (accept && is_search) begin
          state_next = range_empty ? stbs_pkg::ST_REPORT : stbs_pkg::ST_READ;
        end
      end
      stbs_pkg::ST_READ: begin
        state_next = stbs_pkg::ST_COMPARE;
      end
      stbs_pkg::ST_COMPARE: begin
        if (!hit && (go_up || go_down)) begin
          state_next = stbs_pkg::ST_READ;
        end else begin
          state_next = stbs_pkg::ST_REPORT;
        end
      end
      stbs_pkg::ST_REPORT: begin
        state_next = stbs_pkg::ST_IDLE;
      end
      default: begin
        state_next = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and memory port.
  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(XW'(mid_calc));
    ram_wdata = data_value;
    unique case (state)
      stbs_pkg::ST_IDLE: begin
        busy     = 1'b0;
        ram_addr = AW'(XW'(position));
        ram_we   = accept && !is_search && pos_in_table;
      end
      stbs_pkg::ST_READ: begin
        ram_addr = AW'(XW'(mid_calc));
      end
      stbs_pkg::ST_COMPARE: begin
        busy = 1'b1;
      end
      stbs_pkg::ST_REPORT: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Range bounds and the found flag.
  always_comb begin
    lo_next    = lo;
    hi_next    = hi;
    found_next = found;
    unique case (state)
      stbs_pkg::ST_IDLE: begin
        if (accept && is_search) begin
          lo_next    = range_low;
          hi_next    = hi_clamped;
          found_next = 1'b0;
        end
      end
      stbs_pkg::ST_COMPARE: begin
        if (hit) begin
          found_next = 1'b1;
        end else if (go_up) begin
          lo_next = mid + 1'b1;
        end else if (go_down) begin
          hi_next = mid - 1'b1;
        end
      end
      default: begin
        found_next = found;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi    <= hi_next;
    found <= found_next;
    if (state == stbs_pkg::ST_READ) begin
      mid <= mid_calc;
    end
    if (accept && is_search) begin
      key <= data_value;
    end
  end

endmodule
